// ===== rtl/core/lqi_pkg.sv =====
// Shared constants, register codes and width helpers for the line/quad intersection unit.
package lqi_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int POINT_WIDTH     = 32;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int QUEUE_DEPTH     = 8;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CORNER_ZERO  = 3'd0,
    REG_CORNER_ONE   = 3'd1,
    REG_CORNER_TWO   = 3'd2,
    REG_CORNER_THREE = 3'd3
  } cfg_reg_t;

  localparam logic signed [POINT_WIDTH-1:0] POINT_MAX = {1'b0, {(POINT_WIDTH-1){1'b1}}};
  localparam logic signed [POINT_WIDTH-1:0] POINT_MIN = {1'b1, {(POINT_WIDTH-1){1'b0}}};

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // plane normal component width
  function automatic int norm_width(input int cw);
    return 2 * cw + 3;
  endfunction

  // width of n.(B-A) and n.(P0-A)
  function automatic int dot_width(input int cw);
    return 3 * cw + 6;
  endfunction

  // queue entry: parallel flag, A, B-A, numerator, denominator
  function automatic int rec_width(input int cw);
    return 1 + 3 * cw + 3 * (cw + 1) + 2 * dot_width(cw);
  endfunction

  // quotient magnitude bits kept; anything larger saturates for sure
  function automatic int quot_bits(input int cw, input int fb);
    return max2(cw + fb - 1, POINT_WIDTH) + 1;
  endfunction

endpackage

// ===== rtl/core/lqi_ifs.sv =====
// Request and result channel interfaces of the line/quad intersection unit.
interface lqi_in_if #(
  parameter int COORD_WIDTH = lqi_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface lqi_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  hit;
  logic                                  plane_hit;
  logic signed [lqi_pkg::POINT_WIDTH-1:0] point_x;
  logic signed [lqi_pkg::POINT_WIDTH-1:0] point_y;
  logic signed [lqi_pkg::POINT_WIDTH-1:0] point_z;

  modport source (output valid, hit, plane_hit, point_x, point_y, point_z, input ready);
  modport sink   (input valid, hit, plane_hit, point_x, point_y, point_z, output ready);
endinterface

// ===== rtl/core/lqi_queue.sv =====
// Small first-word-fall-through queue between front and back.
module lqi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lqi_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import lqi_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rdata     = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

// ===== rtl/core/lqi_front.sv =====
// Front end: takes requests, forms B-A, n.(B-A), n.(P0-A) and flags parallel lines.
module lqi_front #(
  parameter int COORD_WIDTH = lqi_pkg::COORD_WIDTH_DEF,
  parameter int DEPTH       = lqi_pkg::QUEUE_DEPTH
) (
  input  logic                                          clk,
  input  logic                                          rst,
  lqi_in_if.sink                                        line_in,
  input  logic [3*COORD_WIDTH-1:0]                      corner_zero,
  input  logic [3*lqi_pkg::norm_width(COORD_WIDTH)-1:0] nrm_flat,
  input  logic [$clog2(DEPTH+1)-1:0]                    q_count,
  output logic                                          rec_valid,
  output logic [lqi_pkg::rec_width(COORD_WIDTH)-1:0]    rec
);
  import lqi_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int NW   = norm_width(CW);
  localparam int PW   = NW + DW;
  localparam int DENW = dot_width(CW);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic                   v1, v2, v3, v4;
  logic signed [CW-1:0]   a1 [3];
  logic signed [CW-1:0]   b1 [3];
  logic signed [CW-1:0]   a2 [3];
  logic signed [DW-1:0]   d2 [3];
  logic signed [DW-1:0]   e2 [3];
  logic signed [CW-1:0]   a3 [3];
  logic signed [DW-1:0]   d3 [3];
  logic signed [PW-1:0]   pd3 [3];
  logic signed [PW-1:0]   pe3 [3];
  logic signed [CW-1:0]   a4 [3];
  logic signed [DW-1:0]   d4 [3];
  logic signed [DENW-1:0] den4;
  logic signed [DENW-1:0] num4;
  logic signed [NW-1:0]   nrm [3];
  logic signed [CW-1:0]   p0 [3];
  logic [CNTW:0]          pending;
  logic                   accept;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nrm[j] = nrm_flat[j*NW +: NW];
      p0[j]  = corner_zero[j*CW +: CW];
    end
  end

  // every request in flight here has a queue slot reserved
  assign pending = (CNTW+1)'(q_count) + (CNTW+1)'(v1) + (CNTW+1)'(v2)
                 + (CNTW+1)'(v3) + (CNTW+1)'(v4);
  assign line_in.ready = (pending < (CNTW+1)'(DEPTH));
  assign accept = line_in.valid && line_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    a1[0] <= line_in.start_x;
    a1[1] <= line_in.start_y;
    a1[2] <= line_in.start_z;
    b1[0] <= line_in.end_x;
    b1[1] <= line_in.end_y;
    b1[2] <= line_in.end_z;
    for (int j = 0; j < 3; j++) begin
      a2[j]  <= a1[j];
      d2[j]  <= DW'(b1[j]) - DW'(a1[j]);
      e2[j]  <= DW'(p0[j]) - DW'(a1[j]);
      a3[j]  <= a2[j];
      d3[j]  <= d2[j];
      pd3[j] <= PW'(nrm[j]) * PW'(d2[j]);
      pe3[j] <= PW'(nrm[j]) * PW'(e2[j]);
      a4[j]  <= a3[j];
      d4[j]  <= d3[j];
    end
    den4 <= DENW'(pd3[0]) + DENW'(pd3[1]) + DENW'(pd3[2]);
    num4 <= DENW'(pe3[0]) + DENW'(pe3[1]) + DENW'(pe3[2]);
  end

  assign rec_valid = v4;
  assign rec = {(den4 == '0), a4[2], a4[1], a4[0], d4[2], d4[1], d4[0], num4, den4};

endmodule

// ===== rtl/core/lqi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module lqi_div #(
  parameter int DVW  = 96,
  parameter int DENW = 54,
  parameter int QB   = 33
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [DVW-1:0]  dividend,
  input  logic signed [DENW-1:0] divisor,
  output logic [QB-1:0]          quo,
  output logic                   neg,
  output logic                   sat
);
  import lqi_pkg::*;

  localparam int RW = max2(DVW, DENW + QB) + 1;

  logic [RW-1:0]   rem   [QB];
  logic [QB-1:0]   qv    [QB+1];
  logic [DENW-1:0] ud    [QB];
  logic            neg_s [QB+1];
  logic            sat_s [QB+1];
  logic [DVW-1:0]  un_in;
  logic [DENW-1:0] ud_in;

  assign un_in = dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);
  assign ud_in = divisor[DENW-1] ? DENW'(-divisor) : DENW'(divisor);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= RW'(un_in);
      ud[0]    <= ud_in;
      qv[0]    <= '0;
      neg_s[0] <= dividend[DVW-1] ^ divisor[DENW-1];
      sat_s[0] <= (RW'(un_in) >= (RW'(ud_in) << QB));
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    localparam int BITPOS = QB - s;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = RW'(ud[s-1]) << BITPOS;
    assign take  = (rem[s-1] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        qv[s]    <= qv[s-1] | (take ? (QB'(1) << BITPOS) : '0);
        neg_s[s] <= neg_s[s-1];
        sat_s[s] <= sat_s[s-1];
      end
    end
    if (s < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= take ? rem[s-1] - trial : rem[s-1];
          ud[s]  <= ud[s-1];
        end
      end
    end
  end

  assign quo = qv[QB];
  assign neg = neg_s[QB];
  assign sat = sat_s[QB];

endmodule

// ===== rtl/core/lqi_back.sv =====
// Back end: point along the line, saturation, edge orientation test and result register.
module lqi_back #(
  parameter int COORD_WIDTH = lqi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = lqi_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_not_empty,
  input  logic [lqi_pkg::rec_width(COORD_WIDTH)-1:0]    q_data,
  output logic                                          q_pop,
  input  logic [12*COORD_WIDTH-1:0]                     corner_flat,
  input  logic [3*lqi_pkg::norm_width(COORD_WIDTH)-1:0] nrm_flat,
  lqi_out_if.source                                     point_out
);
  import lqi_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int DW   = CW + 1;
  localparam int NW   = norm_width(CW);
  localparam int DENW = dot_width(CW);
  localparam int RECW = rec_width(CW);
  localparam int PW   = DENW + DW;
  localparam int DVW  = PW + FB;
  localparam int QB   = quot_bits(CW, FB);
  localparam int LAT  = QB + 1;
  localparam int VW   = max2(CW + FB, QB + 1) + 1;
  localparam int UW   = max2(CW + FB, POINT_WIDTH) + 1;
  localparam int MW   = 2 * UW;
  localparam int CRW  = MW + 1;
  localparam int OPW  = CRW + NW;
  localparam int OSW  = OPW + 2;
  localparam int PTW  = POINT_WIDTH;
  // edge cross component split into an unsigned low half and a signed high half
  localparam int SPL  = CRW / 2;
  localparam int PLW  = SPL + 1 + NW;
  localparam int PHW  = CRW - SPL + NW;

  logic en;
  logic signed [NW-1:0] nrm  [3];
  logic signed [CW-1:0] crn  [4][3];

  // stage 0: queue entry
  logic                   v0, par0;
  logic signed [CW-1:0]   a0 [3];
  logic signed [DW-1:0]   d0 [3];
  logic signed [DENW-1:0] num0, den0;
  // stage 1: num*(B-A)
  logic                   v1, par1;
  logic signed [CW-1:0]   a1 [3];
  logic signed [DENW-1:0] den1;
  logic signed [PW-1:0]   prod1 [3];
  // divider side pipe
  logic                   vd   [LAT];
  logic                   pard [LAT];
  logic signed [CW-1:0]   ad   [LAT][3];
  logic [QB-1:0]          quo  [3];
  logic                   qneg [3];
  logic                   qsat [3];
  // stage 2: saturated point
  logic                   v2, par2;
  logic signed [PTW-1:0]  x2 [3];
  logic signed [PTW-1:0]  x2_next [3];
  // stage 3: cross products
  logic                   v3, par3;
  logic signed [PTW-1:0]  x3 [3];
  logic signed [MW-1:0]   m3 [4][6];
  logic signed [MW-1:0]   m3_next [4][6];
  // stage 4: edge cross vectors
  logic                   v4, par4;
  logic signed [PTW-1:0]  x4 [3];
  logic signed [CRW-1:0]  c4 [4][3];
  // stage 5: partial products with normal
  logic                   v5, par5;
  logic signed [PTW-1:0]  x5 [3];
  logic signed [PLW-1:0]  ol5 [4][3];
  logic signed [PHW-1:0]  oh5 [4][3];
  // result register
  logic                   vo, hit_o, plane_o;
  logic signed [PTW-1:0]  pt_o [3];
  logic                   hit_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nrm[j] = nrm_flat[j*NW +: NW];
      for (int k = 0; k < 4; k++) begin
        crn[k][j] = corner_flat[(3*k+j)*CW +: CW];
      end
    end
  end

  assign en    = !vo || point_out.ready;
  assign q_pop = en && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vo <= 1'b0;
      for (int s = 0; s < LAT; s++) begin
        vd[s] <= 1'b0;
      end
    end else if (en) begin
      v0    <= q_not_empty;
      v1    <= v0;
      vd[0] <= v1;
      for (int s = 1; s < LAT; s++) begin
        vd[s] <= vd[s-1];
      end
      v2 <= vd[LAT-1];
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vo <= v5;
    end
  end

  // unpack order matches the front: {par, A, B-A, num, den}
  always_ff @(posedge clk) begin
    if (en) begin
      par0 <= q_data[RECW-1];
      den0 <= q_data[DENW-1:0];
      num0 <= q_data[2*DENW-1:DENW];
      for (int j = 0; j < 3; j++) begin
        d0[j] <= q_data[2*DENW + j*DW +: DW];
        a0[j] <= q_data[2*DENW + 3*DW + j*CW +: CW];
      end
      par1 <= par0;
      den1 <= den0;
      for (int j = 0; j < 3; j++) begin
        a1[j]    <= a0[j];
        prod1[j] <= PW'(num0) * PW'(d0[j]);
      end
      pard[0] <= par1;
      ad[0]   <= a1;
      for (int s = 1; s < LAT; s++) begin
        pard[s] <= pard[s-1];
        ad[s]   <= ad[s-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    lqi_div #(
      .DVW  (DVW),
      .DENW (DENW),
      .QB   (QB)
    ) u_div (
      .clk      (clk),
      .en       (en),
      .dividend (DVW'(prod1[j]) <<< FB),
      .divisor  (den1),
      .quo      (quo[j]),
      .neg      (qneg[j]),
      .sat      (qsat[j])
    );
  end

  // A*2^FB + q, clamped to the output range
  always_comb begin
    logic signed [VW-1:0] qs;
    logic signed [VW-1:0] sum;
    for (int j = 0; j < 3; j++) begin
      qs  = qneg[j] ? -VW'(signed'({1'b0, quo[j]})) : VW'(signed'({1'b0, quo[j]}));
      sum = (VW'(ad[LAT-1][j]) <<< FB) + qs;
      if (qsat[j]) begin
        x2_next[j] = qneg[j] ? POINT_MIN : POINT_MAX;
      end else if (sum > VW'(POINT_MAX)) begin
        x2_next[j] = POINT_MAX;
      end else if (sum < VW'(POINT_MIN)) begin
        x2_next[j] = POINT_MIN;
      end else begin
        x2_next[j] = sum[PTW-1:0];
      end
    end
  end

  // (Pk - X) x (Pk+1 - X), corners scaled to the point format
  always_comb begin
    logic signed [UW-1:0] u [4][3];
    int kn;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        u[k][j] = (UW'(crn[k][j]) <<< FB) - UW'(x2[j]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      kn = (k + 1) % 4;
      m3_next[k][0] = MW'(u[k][1]) * MW'(u[kn][2]);
      m3_next[k][1] = MW'(u[k][2]) * MW'(u[kn][1]);
      m3_next[k][2] = MW'(u[k][2]) * MW'(u[kn][0]);
      m3_next[k][3] = MW'(u[k][0]) * MW'(u[kn][2]);
      m3_next[k][4] = MW'(u[k][0]) * MW'(u[kn][1]);
      m3_next[k][5] = MW'(u[k][1]) * MW'(u[kn][0]);
    end
  end

  // strict inside: all four orientations of one sign; halves recombined here
  always_comb begin
    logic signed [OSW-1:0] o;
    logic                  all_neg;
    logic                  all_pos;
    all_neg = 1'b1;
    all_pos = 1'b1;
    for (int k = 0; k < 4; k++) begin
      o = '0;
      for (int j = 0; j < 3; j++) begin
        o = o + (OSW'(oh5[k][j]) <<< SPL) + OSW'(ol5[k][j]);
      end
      all_neg = all_neg && (o < 0);
      all_pos = all_pos && (o > 0);
    end
    hit_next = all_neg || all_pos;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par2 <= pard[LAT-1];
      x2   <= x2_next;
      par3 <= par2;
      x3   <= x2;
      m3   <= m3_next;
      par4 <= par3;
      x4   <= x3;
      for (int k = 0; k < 4; k++) begin
        c4[k][0] <= CRW'(m3[k][0]) - CRW'(m3[k][1]);
        c4[k][1] <= CRW'(m3[k][2]) - CRW'(m3[k][3]);
        c4[k][2] <= CRW'(m3[k][4]) - CRW'(m3[k][5]);
      end
      par5 <= par4;
      x5   <= x4;
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          ol5[k][j] <= PLW'(signed'({1'b0, c4[k][j][SPL-1:0]})) * PLW'(nrm[j]);
          oh5[k][j] <= PHW'($signed(c4[k][j][CRW-1:SPL])) * PHW'(nrm[j]);
        end
      end
      plane_o <= !par5;
      hit_o   <= !par5 && hit_next;
      for (int j = 0; j < 3; j++) begin
        pt_o[j] <= par5 ? POINT_MAX : x5[j];
      end
    end
  end

  assign point_out.valid     = vo;
  assign point_out.hit       = hit_o;
  assign point_out.plane_hit = plane_o;
  assign point_out.point_x   = pt_o[0];
  assign point_out.point_y   = pt_o[1];
  assign point_out.point_z   = pt_o[2];

endmodule

// ===== rtl/core/line_quad_intersection_unit.sv =====
// Top level of the line/quad intersection unit: corner registers, plane normal, front, queue, back.
//
// Usage notes
// - line_in carries one request per handshake: the two points A (start) and B (end)
//   of an infinite line. point_out returns exactly one result per request, in order.
// - Corners are written through cfg_we/cfg_idx/cfg_data (index 0..3 = corner 0..3,
//   packed z:y:x). Other indices are dropped. Write only while no request is in flight.
// - The plane normal (P2-P1)x(P0-P1) is rebuilt from the corners every cycle and
//   registered, so it is ready well before a request reaches the back end.
// - Front: input, difference, normal product and dot sum registers.
//   Queue: 8 entries, first word falls through.
// - Back: queue register, num*(B-A), a divider of Q+1 stages (Q = 33 at default
//   widths, one quotient bit per stage), point clamp, two cross product stages,
//   the normal products and the result register. The divider makes up most of
//   the back end's depth at default widths.
// - Throughput: one request per cycle sustained while point_out.ready stays high. The front only takes a request
//   when a queue slot is reserved for it, so it never stalls internally.
// - When point_out.ready is low with a result shown, the back end freezes and holds
//   that result; the queue fills and line_in.ready drops once every slot is spoken for.
// - Reset (rst, synchronous): corners go to zero, queue and all valid flags clear.
module line_quad_intersection_unit #(
  parameter int COORD_WIDTH = lqi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = lqi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lqi_pkg::CFG_IDX_WIDTH-1:0] cfg_idx,
  input  logic [3*COORD_WIDTH-1:0]          cfg_data,
  lqi_in_if.sink                            line_in,
  lqi_out_if.source                         point_out
);
  import lqi_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int NW    = norm_width(CW);
  localparam int RECW  = rec_width(CW);
  localparam int DEPTH = QUEUE_DEPTH;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [3*CW-1:0]       corner [4];
  logic [12*CW-1:0]      corner_flat;
  logic signed [DW-1:0]  e1 [3];
  logic signed [DW-1:0]  e2 [3];
  logic signed [NW-1:0]  nrm_next [3];
  logic [3*NW-1:0]       nrm_flat;
  logic                  rec_valid;
  logic [RECW-1:0]       rec;
  logic [RECW-1:0]       q_data;
  logic                  q_pop;
  logic                  q_not_empty;
  logic [CNTW-1:0]       q_count;

  // corner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        corner[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_CORNER_ZERO:  corner[0] <= cfg_data;
        REG_CORNER_ONE:   corner[1] <= cfg_data;
        REG_CORNER_TWO:   corner[2] <= cfg_data;
        REG_CORNER_THREE: corner[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign corner_flat = {corner[3], corner[2], corner[1], corner[0]};

  // unnormalised normal; scale does not move t or any sign
  always_comb begin
    logic signed [CW-1:0] p0c, p1c, p2c;
    for (int j = 0; j < 3; j++) begin
      p0c   = corner[0][j*CW +: CW];
      p1c   = corner[1][j*CW +: CW];
      p2c   = corner[2][j*CW +: CW];
      e1[j] = DW'(p2c) - DW'(p1c);
      e2[j] = DW'(p0c) - DW'(p1c);
    end
    nrm_next[0] = NW'(e1[1]) * NW'(e2[2]) - NW'(e1[2]) * NW'(e2[1]);
    nrm_next[1] = NW'(e1[2]) * NW'(e2[0]) - NW'(e1[0]) * NW'(e2[2]);
    nrm_next[2] = NW'(e1[0]) * NW'(e2[1]) - NW'(e1[1]) * NW'(e2[0]);
  end

  always_ff @(posedge clk) begin
    nrm_flat <= {nrm_next[2], nrm_next[1], nrm_next[0]};
  end

  lqi_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .DEPTH       (DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .line_in     (line_in),
    .corner_zero (corner[0]),
    .nrm_flat    (nrm_flat),
    .q_count     (q_count),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  lqi_queue #(
    .WIDTH (RECW),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_valid),
    .wdata     (rec),
    .pop       (q_pop),
    .rdata     (q_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  lqi_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .corner_flat (corner_flat),
    .nrm_flat    (nrm_flat),
    .point_out   (point_out)
  );

endmodule

// ===== rtl/core/lqi_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module lqi_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  valid,
  input logic                                  ready,
  input logic                                  hit,
  input logic                                  plane_hit,
  input logic signed [lqi_pkg::POINT_WIDTH-1:0] point_x,
  input logic signed [lqi_pkg::POINT_WIDTH-1:0] point_y,
  input logic signed [lqi_pkg::POINT_WIDTH-1:0] point_z
);
  import lqi_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result dropped while stalled");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("result shown straight after reset");

  a_parallel_max: assert property (@(posedge clk) disable iff (rst)
    valid && !plane_hit |-> !hit && point_x == POINT_MAX && point_y == POINT_MAX
                            && point_z == POINT_MAX)
    else $error("parallel line result not at maximum");

  a_hit_needs_plane: assert property (@(posedge clk) disable iff (rst)
    valid && hit |-> plane_hit)
    else $error("inside flag without a plane point");

endmodule

bind line_quad_intersection_unit lqi_checker u_lqi_checker (
  .clk       (clk),
  .rst       (rst),
  .valid     (point_out.valid),
  .ready     (point_out.ready),
  .hit       (point_out.hit),
  .plane_hit (point_out.plane_hit),
  .point_x   (point_out.point_x),
  .point_y   (point_out.point_y),
  .point_z   (point_out.point_z)
);
